>>> rtl/rti_pkg.sv
`timescale 1ns / 1ps

package rti_pkg;

    // Default coordinate width (low bits of each coordinate that are used).
    localparam int COORD_WIDTH_DEF = 32;

    // Field widths of the interface.
    localparam int CRD_W  = 32;
    localparam int DIR_W  = 18;
    localparam int DIST_W = 32;
    localparam int THR_W  = 32;
    localparam int CODE_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Internal arithmetic widths.
    localparam int EDGE_W = CRD_W + 1;              // e1, e2, s
    localparam int P_W    = DIR_W + EDGE_W + 1;     // p = dir x e2
    localparam int Q_W    = 2 * EDGE_W + 1;         // q = s x e1
    localparam int DET_W  = EDGE_W + P_W + 2;       // det, nu, nv
    localparam int NT_W   = EDGE_W + Q_W + 2;       // nt
    localparam int FRAC_SHIFT = 16;                 // t = nt * 2^16 / det
    localparam int SAT_W  = DET_W + FRAC_SHIFT + 1;

    // Packed stream widths.
    localparam int NUM_IN_CRD   = 9;
    localparam int IN_TDATA_W   = NUM_IN_CRD * CRD_W + DIST_W;
    localparam int OUT_FIELDS_W = 1 + DIST_W + CODE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Reset value of the determinant threshold.
    localparam logic [THR_W-1:0] DET_THR_RESET = THR_W'(42950);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z,
        REG_DET_THR
    } cfg_reg_t;

    // Outcome codes.
    typedef enum logic [CODE_W-1:0] {
        OUT_HIT    = 3'd0,
        OUT_DEGEN  = 3'd1,
        OUT_U_OUT  = 3'd2,
        OUT_V_OUT  = 3'd3,
        OUT_FAR    = 3'd4
    } outcome_t;

    // Side information that travels with an item through the divider.
    typedef struct packed {
        outcome_t          code;
        logic              cand;
        logic              sat;
        logic [DIST_W-1:0] best;
    } div_side_t;

endpackage

>>> rtl/rti_mul.sv
`timescale 1ns / 1ps

// Two-stage signed multiplier: the second operand is split into a low
// unsigned half and a high signed half, and the partial products are
// joined in the second stage.
module rti_mul #(
    parameter int AW = 33,
    parameter int BW = 52
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  p
);

    localparam int LW = BW / 2;
    localparam int HW = BW - LW;

    logic signed [AW+LW:0]    lo_reg;
    logic signed [AW+HW-1:0]  hi_reg;
    logic signed [AW+BW-1:0]  p_reg;

    // Partial products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= a * $signed({1'b0, b[LW-1:0]});
            hi_reg <= a * $signed(b[BW-1:LW]);
        end
    end

    // Recombine.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= ((AW+BW)'(hi_reg) <<< LW) + (AW+BW)'(lo_reg);
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/rti_delay.sv
`timescale 1ns / 1ps

// Payload delay line that advances with the pipeline enable.
module rti_delay #(
    parameter int W = 32,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[N-1];

endmodule

>>> rtl/rti_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage. The caller
// guarantees that the starting remainder is below the divisor whenever
// the quotient is used.
module rti_div #(
    parameter int DW = 87,
    parameter int QW = 32,
    parameter int SW = 37
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem,
    input  logic [QW-1:0] low,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_o
);

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   r2;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = rem;
            assign low_in  = low;
            assign den_in  = den;
            assign quo_in  = '0;
            assign side_in = side;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign low_in  = low_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // Shift in the next numerator bit and try the subtraction.
        assign r2   = {rem_in, low_in[QW-1]};
        assign diff = r2 - {1'b0, den_in};
        assign ge   = (r2 >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
                low_reg[k]  <= low_in << 1;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= {quo_in[QW-2:0], ge};
                side_reg[k] <= side_in;
            end
        end
    end

    assign quo    = quo_reg[QW-1];
    assign side_o = side_reg[QW-1];

endmodule

>>> rtl/ray_triangle_intersect_top.sv
`timescale 1ns / 1ps

// Moller-Trumbore ray/triangle test in exact fixed point. The user must
// load the ray origin, direction and determinant threshold through the
// register port only while the block is idle; the block does not enforce
// this. Unless stalled, the slave stream accepts one triangle per cycle
// and the master stream returns one result per triangle, in order.
// Stages: nine arithmetic (edges, cross products, dot products, sign fix,
// classification), 32 in the divider that forms the distance one
// quotient bit per stage, and the output register. Back pressure on the
// master side freezes every stage unless the output register is empty.
module ray_triangle_intersect_top #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rti_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, best_distance
    input  logic [rti_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit, new_distance, outcome, zero padding
    output logic [rti_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import rti_pkg::*;

    localparam int USE_BITS = (COORD_WIDTH > CRD_W) ? CRD_W : COORD_WIDTH;
    localparam int SH       = CRD_W - USE_BITS;
    localparam int QUO_W    = DIST_W;
    localparam int PRE_LAT  = 9;
    localparam int LAT      = PRE_LAT + QUO_W + 1;
    localparam int SIDE_W   = $bits(div_side_t);

    // Sign-extend the used low bits of a coordinate to the edge width.
    function automatic logic signed [EDGE_W-1:0] crd(input logic [CRD_W-1:0] v);
        logic [CRD_W-1:0] t;
        t = v << SH;
        return EDGE_W'($signed(t) >>> SH);
    endfunction

    // Configuration registers.
    logic [CRD_W-1:0]        origin_reg [3];
    logic signed [DIR_W-1:0] dir_reg    [3];
    logic [THR_W-1:0]        thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i] <= '0;
                dir_reg[i]    <= '0;
            end
            thr_reg <= DET_THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X: origin_reg[0] <= cfg_data[CRD_W-1:0];
                REG_ORIGIN_Y: origin_reg[1] <= cfg_data[CRD_W-1:0];
                REG_ORIGIN_Z: origin_reg[2] <= cfg_data[CRD_W-1:0];
                REG_DIR_X:    dir_reg[0]    <= $signed(cfg_data[DIR_W-1:0]);
                REG_DIR_Y:    dir_reg[1]    <= $signed(cfg_data[DIR_W-1:0]);
                REG_DIR_Z:    dir_reg[2]    <= $signed(cfg_data[DIR_W-1:0]);
                REG_DET_THR:  thr_reg       <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline enable and valid chain.
    logic           en;
    logic [LAT-1:0] valid_reg;

    assign en       = m_tready | ~valid_reg[LAT-1];
    assign s_tready = en;
    assign m_tvalid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end

    // Unpack the input transaction.
    logic [CRD_W-1:0]  vin [NUM_IN_CRD];
    logic [DIST_W-1:0] best_in;

    for (genvar i = 0; i < NUM_IN_CRD; i++)
    begin : g_unpack
        assign vin[i] = s_tdata[CRD_W*i +: CRD_W];
    end
    assign best_in = s_tdata[NUM_IN_CRD*CRD_W +: DIST_W];

    // Stage 1: edges and origin offset.
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];
    logic signed [EDGE_W-1:0] s_reg  [3];
    logic [DIST_W-1:0]        best1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                e1_reg[c] <= crd(vin[3+c]) - crd(vin[c]);
                e2_reg[c] <= crd(vin[6+c]) - crd(vin[c]);
                s_reg[c]  <= crd(origin_reg[c]) - crd(vin[c]);
            end
            best1_reg <= best_in;
        end
    end

    // Stages 2 to 4: cross products p = dir x e2 and q = s x e1.
    logic signed [P_W-1:0]    p_reg  [3];
    logic signed [Q_W-1:0]    q_reg  [3];
    logic signed [EDGE_W-1:0] e1_d   [3];
    logic signed [EDGE_W-1:0] e2_d   [3];
    logic signed [EDGE_W-1:0] s_d    [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_cross
        localparam int C1 = (c + 1) % 3;
        localparam int C2 = (c + 2) % 3;
        logic signed [DIR_W+EDGE_W-1:0] pa, pb;
        logic signed [2*EDGE_W-1:0]     qa, qb;
        logic [3*EDGE_W-1:0]            vec_d;

        rti_mul #(.AW(DIR_W), .BW(EDGE_W)) u_pa (
            .clk(clk), .en(en), .a(dir_reg[C1]), .b(e2_reg[C2]), .p(pa));
        rti_mul #(.AW(DIR_W), .BW(EDGE_W)) u_pb (
            .clk(clk), .en(en), .a(dir_reg[C2]), .b(e2_reg[C1]), .p(pb));
        rti_mul #(.AW(EDGE_W), .BW(EDGE_W)) u_qa (
            .clk(clk), .en(en), .a(s_reg[C1]), .b(e1_reg[C2]), .p(qa));
        rti_mul #(.AW(EDGE_W), .BW(EDGE_W)) u_qb (
            .clk(clk), .en(en), .a(s_reg[C2]), .b(e1_reg[C1]), .p(qb));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[c] <= P_W'(pa) - P_W'(pb);
                q_reg[c] <= Q_W'(qa) - Q_W'(qb);
            end
        end

        // Keep the edges aligned with the cross products.
        rti_delay #(.W(3*EDGE_W), .N(3)) u_vec_d (
            .clk(clk), .en(en),
            .d({e1_reg[c], e2_reg[c], s_reg[c]}), .q(vec_d));
        assign e1_d[c] = $signed(vec_d[3*EDGE_W-1:2*EDGE_W]);
        assign e2_d[c] = $signed(vec_d[2*EDGE_W-1:EDGE_W]);
        assign s_d[c]  = $signed(vec_d[EDGE_W-1:0]);
    end

    // Stages 5 to 7: dot products det, nu, nv, nt.
    logic signed [EDGE_W+P_W-1:0]   det_t [3];
    logic signed [EDGE_W+P_W-1:0]   nu_t  [3];
    logic signed [DIR_W+Q_W-1:0]    nv_t  [3];
    logic signed [EDGE_W+Q_W-1:0]   nt_t  [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_dot
        rti_mul #(.AW(EDGE_W), .BW(P_W)) u_det (
            .clk(clk), .en(en), .a(e1_d[c]), .b(p_reg[c]), .p(det_t[c]));
        rti_mul #(.AW(EDGE_W), .BW(P_W)) u_nu (
            .clk(clk), .en(en), .a(s_d[c]), .b(p_reg[c]), .p(nu_t[c]));
        rti_mul #(.AW(DIR_W), .BW(Q_W)) u_nv (
            .clk(clk), .en(en), .a(dir_reg[c]), .b(q_reg[c]), .p(nv_t[c]));
        rti_mul #(.AW(EDGE_W), .BW(Q_W)) u_nt (
            .clk(clk), .en(en), .a(e2_d[c]), .b(q_reg[c]), .p(nt_t[c]));
    end

    logic signed [DET_W-1:0] det_reg, nu_reg, nv_reg;
    logic signed [NT_W-1:0]  nt_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= DET_W'(det_t[0]) + DET_W'(det_t[1]) + DET_W'(det_t[2]);
            nu_reg  <= DET_W'(nu_t[0]) + DET_W'(nu_t[1]) + DET_W'(nu_t[2]);
            nv_reg  <= DET_W'(nv_t[0]) + DET_W'(nv_t[1]) + DET_W'(nv_t[2]);
            nt_reg  <= NT_W'(nt_t[0]) + NT_W'(nt_t[1]) + NT_W'(nt_t[2]);
        end
    end

    // Stage 8: make the determinant positive.
    logic signed [DET_W-1:0] detn_reg, nun_reg, nvn_reg;
    logic signed [NT_W-1:0]  ntn_reg;
    logic [DIST_W-1:0]       best8;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (det_reg[DET_W-1])
            begin
                detn_reg <= -det_reg;
                nun_reg  <= -nu_reg;
                nvn_reg  <= -nv_reg;
                ntn_reg  <= -nt_reg;
            end
            else
            begin
                detn_reg <= det_reg;
                nun_reg  <= nu_reg;
                nvn_reg  <= nv_reg;
                ntn_reg  <= nt_reg;
            end
        end
    end

    rti_delay #(.W(DIST_W), .N(PRE_LAT - 2)) u_best_d (
        .clk(clk), .en(en), .d(best1_reg), .q(best8));

    // Stage 9: classification and divider set-up.
    logic signed [DET_W:0]   uv_sum;
    logic                    degen, u_out, v_out, t_bad, sat;
    outcome_t                code_next;
    div_side_t               side_reg;
    logic [DET_W-1:0]        rem0_reg;
    logic [QUO_W-1:0]        low0_reg;
    logic [DET_W-1:0]        den_reg;

    assign uv_sum = (DET_W+1)'(nun_reg) + (DET_W+1)'(nvn_reg);
    assign degen  = (detn_reg == '0) || (detn_reg < $signed(DET_W'(thr_reg)));
    assign u_out  = nun_reg[DET_W-1] || (nun_reg > detn_reg);
    assign v_out  = nvn_reg[DET_W-1] || (uv_sum > (DET_W+1)'(detn_reg));
    assign t_bad  = ntn_reg[NT_W-1] || (ntn_reg == '0);
    assign sat    = $signed(SAT_W'(ntn_reg))
                    >= $signed(SAT_W'({detn_reg, {FRAC_SHIFT{1'b0}}}));

    always_comb
    begin
        priority if (degen) code_next = OUT_DEGEN;
        else if (u_out)     code_next = OUT_U_OUT;
        else if (v_out)     code_next = OUT_V_OUT;
        else if (t_bad)     code_next = OUT_FAR;
        else                code_next = OUT_HIT;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg.code <= code_next;
            side_reg.cand <= (code_next == OUT_HIT);
            side_reg.sat  <= sat;
            side_reg.best <= best8;
            rem0_reg      <= DET_W'(ntn_reg[NT_W-1:FRAC_SHIFT]);
            low0_reg      <= {ntn_reg[FRAC_SHIFT-1:0], {(QUO_W-FRAC_SHIFT){1'b0}}};
            den_reg       <= detn_reg;
        end
    end

    // Stages 10 to 41: distance division.
    logic [QUO_W-1:0]  quo;
    logic [SIDE_W-1:0] side_out;
    div_side_t         side_o;

    rti_div #(.DW(DET_W), .QW(QUO_W), .SW(SIDE_W)) u_div (
        .clk(clk), .en(en), .rem(rem0_reg), .low(low0_reg), .den(den_reg),
        .side(side_reg), .quo(quo), .side_o(side_out));

    assign side_o = div_side_t'(side_out);

    // Stage 42: final compare and output register.
    logic [DIST_W-1:0] tval;
    logic              closer;
    logic              hit_reg;
    logic [DIST_W-1:0] dist_reg;
    outcome_t          code_reg;

    assign tval   = side_o.sat ? {DIST_W{1'b1}} : quo;
    assign closer = side_o.cand && (tval < side_o.best);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= closer;
            if (closer)
            begin
                dist_reg <= tval;
                code_reg <= OUT_HIT;
            end
            else
            begin
                dist_reg <= side_o.best;
                code_reg <= side_o.cand ? OUT_FAR : side_o.code;
            end
        end
    end

    assign m_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, code_reg, dist_reg, hit_reg};

    // A hit is always reported with the hit code.
    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (hit_reg == (code_reg == OUT_HIT)))
        else $error("hit flag and outcome code disagree");

    // A saturated distance can never be a hit.
    a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && hit_reg) |-> (dist_reg != {DIST_W{1'b1}}))
        else $error("hit with saturated distance");

    // A stall freezes every valid bit of the pipeline.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");

endmodule
